// ----- rtl/core/hptd_pkg.sv -----
// ----------------------------------------------------------------------------
// hptd_pkg
// Shared types and constants for the preorder-tree Huffman decoder.
// ----------------------------------------------------------------------------
package hptd_pkg;

    // default alphabet size
    localparam int unsigned ALPHABET_SIZE_DEF = 256;

    // frame parse phases
    typedef enum logic [2:0] {
        PH_COUNT_HI = 3'd0,
        PH_COUNT_LO = 3'd1,
        PH_LEAVES   = 3'd2,
        PH_SLEN_HI  = 3'd3,
        PH_SLEN_LO  = 3'd4,
        PH_TREE     = 3'd5,
        PH_CODE     = 3'd6,
        PH_DEAD     = 3'd7
    } phase_t;

    // result kinds
    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;

    // structure byte that marks a leaf
    localparam logic [7:0] LEAF_BYTE = 8'd1;

endpackage

// ----- rtl/core/hptd_ram.sv -----
// ----------------------------------------------------------------------------
// hptd_ram
// Simple dual-port RAM, one write and one registered read port, write-first.
// ----------------------------------------------------------------------------
module hptd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read, new data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata <= wdata;
            end
            else
            begin
                rdata <= mem[raddr];
            end
        end
    end

endmodule

// ----- rtl/core/huffman_preorder_tree_decoder_top.sv -----
// Result path: a decoded symbol or error passes through the a stage, then the out stage, to out_valid.
// Throughput: one byte per cycle while in_stall is low; the tree walk reads both child tables each
// cycle at the next node address, so consecutive code bits never wait.
// Reset: rst_n clears the parser to the leaf count phase and empties both
// result stages; the RAMs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// huffman_preorder_tree_decoder_top
// Parses the frame header, builds the tree from preorder bytes and walks it.
// ----------------------------------------------------------------------------
module huffman_preorder_tree_decoder_top
    import hptd_pkg::*;
#(
    parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       frame_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       out_kind,
    output logic [7:0] out_symbol
);

    localparam int unsigned IW = $clog2(ALPHABET_SIZE);
    localparam int unsigned CW = $clog2(ALPHABET_SIZE + 1);

    // parser state
    phase_t          phase_reg, phase_next;
    logic [7:0]      cnt_hi_reg, cnt_hi_next;
    logic [CW-1:0]   countdown_reg, countdown_next;
    logic [CW-1:0]   leaf_total_reg, leaf_total_next;
    logic [CW-1:0]   taken_reg, taken_next;
    logic [CW-1:0]   internal_reg, internal_next;
    logic [CW-1:0]   depth_reg, depth_next;
    logic [IW:0]     top_reg, top_next;
    logic [IW-1:0]   walk_reg, walk_next;

    // result stages
    logic            a_valid_reg, a_kind_reg;
    logic            out_valid_reg, out_kind_reg;
    logic [7:0]      out_symbol_reg;

    logic            accept, a_move, emit, err;
    logic [15:0]     count_word;
    logic            leaf_we;
    logic [IW-1:0]   leaf_waddr, leaf_raddr;
    logic [7:0]      leaf_q;
    logic            kid_we_l, kid_we_r;
    logic [IW-1:0]   kid_waddr;
    logic [IW:0]     kid_wdata, left_q, right_q, child_sel;
    logic            pend_we;
    logic [IW-1:0]   pend_addr;
    logic [IW:0]     pend_wdata, pend_q;

    // handshake
    assign a_move   = a_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = a_valid_reg && !a_move;
    assign accept   = in_valid && !in_stall;

    assign count_word = {cnt_hi_reg, in_byte};
    assign child_sel  = (in_byte == 8'd0) ? left_q : right_q;
    assign pend_addr  = IW'(depth_next - CW'(2));

    // parse, build and walk
    always_comb
    begin
        phase_next      = phase_reg;
        cnt_hi_next     = cnt_hi_reg;
        countdown_next  = countdown_reg;
        leaf_total_next = leaf_total_reg;
        taken_next      = taken_reg;
        internal_next   = internal_reg;
        depth_next      = depth_reg;
        top_next        = top_reg;
        walk_next       = walk_reg;
        emit            = 1'b0;
        err             = 1'b0;
        leaf_we         = 1'b0;
        leaf_waddr      = IW'(leaf_total_reg - countdown_reg);
        leaf_raddr      = child_sel[IW-1:0];
        kid_we_l        = 1'b0;
        kid_we_r        = 1'b0;
        kid_waddr       = top_reg[IW:1];
        kid_wdata       = '0;
        pend_we         = 1'b0;
        pend_wdata      = {IW'(internal_reg), 1'b1};
        if (accept)
        begin
            case (phase_reg)
                PH_COUNT_HI:
                begin
                    cnt_hi_next = in_byte;
                    phase_next  = PH_COUNT_LO;
                end
                PH_COUNT_LO:
                begin
                    if ({1'b0, count_word} > 17'(ALPHABET_SIZE))
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        leaf_total_next = CW'(count_word);
                        countdown_next  = CW'(count_word);
                        phase_next = (count_word != 16'd0) ? PH_LEAVES : PH_SLEN_HI;
                    end
                end
                PH_LEAVES:
                begin
                    leaf_we        = 1'b1;
                    countdown_next = countdown_reg - CW'(1);
                    if (countdown_reg == CW'(1))
                    begin
                        phase_next = PH_SLEN_HI;
                    end
                end
                PH_SLEN_HI:
                begin
                    phase_next = PH_SLEN_LO;
                end
                PH_SLEN_LO:
                begin
                    phase_next = PH_TREE;
                end
                PH_TREE:
                begin
                    if (internal_reg == '0)
                    begin
                        // root must be internal
                        if (in_byte == LEAF_BYTE)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            internal_next = CW'(1);
                            depth_next    = CW'(2);
                            top_next      = '0;
                            pend_we       = 1'b1;
                        end
                    end
                    else if (depth_reg == '0)
                    begin
                        err = 1'b1;
                    end
                    else if (in_byte == LEAF_BYTE)
                    begin
                        // leaf fills the popped slot
                        if (taken_reg >= leaf_total_reg)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            kid_wdata  = {1'b1, IW'(taken_reg)};
                            kid_we_l   = !top_reg[0];
                            kid_we_r   = top_reg[0];
                            taken_next = taken_reg + CW'(1);
                            depth_next = depth_reg - CW'(1);
                            top_next   = pend_q;
                        end
                    end
                    else
                    begin
                        // new internal node fills the slot, pushes right then left
                        if (internal_reg >= CW'(ALPHABET_SIZE - 1) ||
                            depth_reg >= CW'(ALPHABET_SIZE))
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            kid_wdata     = {1'b0, IW'(internal_reg)};
                            kid_we_l      = !top_reg[0];
                            kid_we_r      = top_reg[0];
                            internal_next = internal_reg + CW'(1);
                            depth_next    = depth_reg + CW'(1);
                            top_next      = {IW'(internal_reg), 1'b0};
                            pend_we       = 1'b1;
                        end
                    end
                    if (!err && depth_next == '0)
                    begin
                        phase_next = PH_CODE;
                        walk_next  = '0;
                    end
                end
                PH_CODE:
                begin
                    if (child_sel[IW])
                    begin
                        emit      = 1'b1;
                        walk_next = '0;
                    end
                    else
                    begin
                        walk_next = child_sel[IW-1:0];
                    end
                end
                default:
                begin
                end
            endcase
            if (err)
            begin
                phase_next = PH_DEAD;
            end
            // end of frame clears the parser
            if (frame_end)
            begin
                phase_next      = PH_COUNT_HI;
                countdown_next  = '0;
                leaf_total_next = '0;
                taken_next      = '0;
                internal_next   = '0;
                depth_next      = '0;
                walk_next       = '0;
            end
        end
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_COUNT_HI;
            countdown_reg  <= '0;
            leaf_total_reg <= '0;
            taken_reg      <= '0;
            internal_reg   <= '0;
            depth_reg      <= '0;
            walk_reg       <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            countdown_reg  <= countdown_next;
            leaf_total_reg <= leaf_total_next;
            taken_reg      <= taken_next;
            internal_reg   <= internal_next;
            depth_reg      <= depth_next;
            walk_reg       <= walk_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_hi_reg <= cnt_hi_next;
        top_reg    <= top_next;
    end

    // result stage: leaf store read lands alongside
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg <= emit || err;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg <= err ? KIND_ERROR : KIND_SYMBOL;
        end
        if (a_move)
        begin
            out_kind_reg   <= a_kind_reg;
            out_symbol_reg <= (a_kind_reg == KIND_ERROR) ? 8'd0 : leaf_q;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_symbol = out_symbol_reg;

    // leaf symbol store
    hptd_ram #(.WIDTH(8), .DEPTH(ALPHABET_SIZE)) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (in_byte),
        .re    (accept),
        .raddr (leaf_raddr),
        .rdata (leaf_q)
    );

    // left children
    hptd_ram #(.WIDTH(IW + 1), .DEPTH(ALPHABET_SIZE)) u_left_ram (
        .clk   (clk),
        .we    (kid_we_l),
        .waddr (kid_waddr),
        .wdata (kid_wdata),
        .re    (1'b1),
        .raddr (walk_next),
        .rdata (left_q)
    );

    // right children
    hptd_ram #(.WIDTH(IW + 1), .DEPTH(ALPHABET_SIZE)) u_right_ram (
        .clk   (clk),
        .we    (kid_we_r),
        .waddr (kid_waddr),
        .wdata (kid_wdata),
        .re    (1'b1),
        .raddr (walk_next),
        .rdata (right_q)
    );

    // pending slots below the top of stack, second entry prefetched
    hptd_ram #(.WIDTH(IW + 1), .DEPTH(ALPHABET_SIZE)) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_addr),
        .wdata (pend_wdata),
        .re    (1'b1),
        .raddr (pend_addr),
        .rdata (pend_q)
    );

endmodule

// ----- rtl/core/hptd_checker.sv -----
// ----------------------------------------------------------------------------
// hptd_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hptd_checker
    import hptd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       out_kind,
    input logic [7:0] out_symbol
);

    // an error result carries a zero symbol
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == KIND_ERROR) |-> (out_symbol == 8'd0))
        else $error("error result with non-zero symbol");

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_kind) && $stable(out_symbol)))
        else $error("stalled result changed");

    // input is only held back while a result is held back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    // one transaction in gives at most one result, so no result appears from nothing
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid ##1 !in_valid ##1 !out_valid) |=> !out_valid)
        else $error("result without a transaction");

endmodule

bind huffman_preorder_tree_decoder_top hptd_checker u_hptd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_symbol (out_symbol)
);
